// ===== rtl/tftd_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-finger tap detector package
// Shared sizes, event codes and the control bundle of the distance unit.
// ----------------------------------------------------------------------------
package tftd_pkg;

  localparam int SLOTS      = 10;
  localparam int COORD_BITS = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int VALUE_W    = 17;
  localparam int LIMIT_W    = 33;
  localparam int MS_W       = 16;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 1;

  // Event codes on func
  localparam logic [2:0] FN_SLOT  = 3'd0;
  localparam logic [2:0] FN_TRACK = 3'd1;
  localparam logic [2:0] FN_POS_X = 3'd2;
  localparam logic [2:0] FN_POS_Y = 3'd3;
  localparam logic [2:0] FN_SYNC  = 3'd4;
  localparam logic [2:0] FN_TICK  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 1'd1;

  localparam logic [VALUE_W-1:0] ID_NONE = '1;
  localparam logic [LIMIT_W-1:0] MOVE_LIMIT_RESET = LIMIT_W'(75 * 75);
  localparam logic [MS_W-1:0]    TIMEOUT_RESET    = MS_W'(200);

  // Steps of one slot in the distance unit
  typedef enum logic [1:0] {
    DP_DX,
    DP_DY,
    DP_SQ,
    DP_CMP
  } dist_phase_t;

  typedef struct packed {
    logic        clr;
    logic        run;
    dist_phase_t phase;
    logic        slot_active;
  } dist_ctl_t;

endpackage

// ===== rtl/tftd_dist_unit.sv =====
// ----------------------------------------------------------------------------
// Movement distance unit
// One shared squarer walks the squared distance of one slot over four steps
// and keeps a sticky flag when an active slot moved past the limit.
// ----------------------------------------------------------------------------
module tftd_dist_unit import tftd_pkg::*; (
  input  logic                  clk,
  input  dist_ctl_t             ctl,
  input  logic [COORD_BITS-1:0] x,
  input  logic [COORD_BITS-1:0] y,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [LIMIT_W-1:0]    move_limit_sq,
  output logic                  moved
);

  logic signed [COORD_BITS:0]       d;
  logic signed [2*COORD_BITS+1:0]   prod;
  logic [2*COORD_BITS-1:0]          sq_x;
  logic [2*COORD_BITS-1:0]          sq_y;
  logic [2*COORD_BITS:0]            sum;

  // Single squarer shared by both axes
  assign prod = d * d;
  assign sum  = {1'b0, sq_x} + {1'b0, sq_y};

  // Step through difference, square and compare
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      moved <= 1'b0;
    end else if (ctl.run) begin
      unique case (ctl.phase)
        DP_DX: begin
          d <= $signed({1'b0, x}) - $signed({1'b0, start_x});
        end
        DP_DY: begin
          sq_x <= prod[2*COORD_BITS-1:0];
          d    <= $signed({1'b0, y}) - $signed({1'b0, start_y});
        end
        DP_SQ: begin
          sq_y <= prod[2*COORD_BITS-1:0];
        end
        DP_CMP: begin
          if (ctl.slot_active && (LIMIT_W'(sum) > move_limit_sq)) begin
            moved <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/two_finger_tap_detector_core.sv =====
// Slot, id, position and tick items are done without leaving idle; a sync that
// latches start positions walks all slots in S_LATCH (one slot copied per cycle).
// A lift under a pending tap runs the shared squarer over every slot (four steps
// a slot); if still and in time, it then offers the press and release items.
// Throughput: one item at a time; ready is low while an item is in work.
// Reset: synchronous, clears all contacts, counters and flags, restores registers.
// ----------------------------------------------------------------------------
// Two-finger tap detector core
// Tracks multitouch slot events and emits a right click for a short, still
// two-finger tap.
// ----------------------------------------------------------------------------
module two_finger_tap_detector_core import tftd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                func,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      button_down,
  output logic                      last_of_run,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [LIMIT_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LATCH,
    S_CHECK,
    S_DECIDE,
    S_PRESS,
    S_RELEASE
  } state_t;

  state_t                  state;
  logic [SLOT_W-1:0]       idx;
  dist_phase_t             phase;
  logic [SLOT_W-1:0]       sel;
  logic [COUNT_W-1:0]      finger_count;
  logic [COUNT_W-1:0]      count_up;
  logic                    tap_pending;
  logic                    starts_latched;
  logic [MS_W-1:0]         tap_elapsed_ms;
  logic                    time_ok;
  logic [SLOTS-1:0]        slot_active;
  logic [LIMIT_W-1:0]      move_limit_sq;
  logic [MS_W-1:0]         tap_limit_ms;

  logic [COORD_BITS-1:0]   slot_x       [SLOTS];
  logic [COORD_BITS-1:0]   slot_y       [SLOTS];
  logic [COORD_BITS-1:0]   slot_start_x [SLOTS];
  logic [COORD_BITS-1:0]   slot_start_y [SLOTS];

  logic                    accept;
  logic [VALUE_W-1:0]      raw;
  logic [COORD_BITS-1:0]   coord;
  logic                    is_lift;
  logic                    is_land;
  logic                    last_slot;
  logic                    moved;
  dist_ctl_t               dctl;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign raw       = value;
  assign coord     = raw[COORD_BITS-1:0];
  assign is_lift   = slot_active[sel] && (raw == ID_NONE);
  assign is_land   = !slot_active[sel] && (raw != ID_NONE);
  assign last_slot = (idx == SLOT_W'(SLOTS - 1));
  assign count_up  = (finger_count != '1) ? finger_count + 1'b1 : finger_count;

  // Drive the shared distance unit
  always_comb begin
    dctl.clr         = accept && (func == FN_TRACK);
    dctl.run         = (state == S_CHECK);
    dctl.phase       = phase;
    dctl.slot_active = slot_active[idx];
  end

  tftd_dist_unit u_dist (
    .clk           (clk),
    .ctl           (dctl),
    .x             (slot_x[idx]),
    .y             (slot_y[idx]),
    .start_x       (slot_start_x[idx]),
    .start_y       (slot_start_y[idx]),
    .move_limit_sq (move_limit_sq),
    .moved         (moved)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      move_limit_sq <= MOVE_LIMIT_RESET;
      tap_limit_ms  <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOVE_LIMIT: move_limit_sq <= cfg_data;
        REG_TIMEOUT:    tap_limit_ms  <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot position table: landing zeroes, position items write, sync sweep copies
  always_ff @(posedge clk) begin
    if (accept && (func == FN_TRACK) && is_land) begin
      slot_x[sel]       <= '0;
      slot_y[sel]       <= '0;
      slot_start_x[sel] <= '0;
      slot_start_y[sel] <= '0;
    end else if (accept && (func == FN_POS_X) && slot_active[sel]) begin
      slot_x[sel] <= coord;
    end else if (accept && (func == FN_POS_Y) && slot_active[sel]) begin
      slot_y[sel] <= coord;
    end else if ((state == S_LATCH) && slot_active[idx]) begin
      slot_start_x[idx] <= slot_x[idx];
      slot_start_y[idx] <= slot_y[idx];
    end
  end

  // Sequencer, contact state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      idx            <= '0;
      phase          <= DP_DX;
      sel            <= '0;
      finger_count   <= '0;
      tap_pending    <= 1'b0;
      starts_latched <= 1'b0;
      tap_elapsed_ms <= '0;
      time_ok        <= 1'b0;
      slot_active    <= '0;
      out_valid      <= 1'b0;
      button_down    <= 1'b0;
      last_of_run    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              FN_SLOT: begin
                if (raw < VALUE_W'(SLOTS)) begin
                  sel <= raw[SLOT_W-1:0];
                end
              end
              FN_TRACK: begin
                if (is_lift) begin
                  if (finger_count != '0) begin
                    finger_count <= finger_count - 1'b1;
                  end
                  if (tap_pending && (finger_count == COUNT_W'(2))) begin
                    // run the movement check before the slot drops
                    tap_pending    <= 1'b0;
                    starts_latched <= 1'b0;
                    time_ok        <= (tap_elapsed_ms < tap_limit_ms);
                    idx            <= '0;
                    phase          <= DP_DX;
                    state          <= S_CHECK;
                  end else begin
                    slot_active[sel] <= 1'b0;
                  end
                end else if (is_land) begin
                  slot_active[sel] <= 1'b1;
                  finger_count     <= count_up;
                  if (count_up == COUNT_W'(2)) begin
                    tap_pending    <= 1'b1;
                    tap_elapsed_ms <= '0;
                    starts_latched <= 1'b0;
                  end else begin
                    tap_pending <= 1'b0;
                  end
                end
              end
              FN_SYNC: begin
                if (tap_pending && (finger_count == COUNT_W'(2)) && !starts_latched) begin
                  starts_latched <= 1'b1;
                  idx            <= '0;
                  state          <= S_LATCH;
                end else if ((finger_count != COUNT_W'(2)) && tap_pending) begin
                  tap_pending    <= 1'b0;
                  starts_latched <= 1'b0;
                end
              end
              FN_TICK: begin
                if (tap_elapsed_ms != '1) begin
                  tap_elapsed_ms <= tap_elapsed_ms + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_LATCH: begin
          // copy one slot per cycle
          if (last_slot) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CHECK: begin
          unique case (phase)
            DP_DX:  phase <= DP_DY;
            DP_DY:  phase <= DP_SQ;
            DP_SQ:  phase <= DP_CMP;
            DP_CMP: begin
              phase <= DP_DX;
              if (last_slot) begin
                state <= S_DECIDE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: phase <= DP_DX;
          endcase
        end
        S_DECIDE: begin
          slot_active[sel] <= 1'b0;
          if (time_ok && !moved) begin
            out_valid   <= 1'b1;
            button_down <= 1'b1;
            last_of_run <= 1'b0;
            state       <= S_PRESS;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PRESS: begin
          if (out_ready) begin
            button_down <= 1'b0;
            last_of_run <= 1'b1;
            state       <= S_RELEASE;
          end
        end
        S_RELEASE: begin
          if (out_ready) begin
            out_valid   <= 1'b0;
            last_of_run <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Never take an item while a click is still being offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while click pending");

  // A taken press is always followed by the closing release
  a_press_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && button_down) |=>
      (out_valid && !button_down && last_of_run))
    else $error("press not followed by release");

  // A pending tap only exists with exactly two fingers down
  a_pending_two: assert property (@(posedge clk) disable iff (rst)
    tap_pending |-> (finger_count == COUNT_W'(2)))
    else $error("tap pending without two fingers");

endmodule

// ===== verif/two_finger_tap_detector_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-finger tap detector core testbench
// Drives slot, tracking id, position, sync and tick items with random gaps.
// A local copy of the contact table predicts each right click. A checker
// compares every press and release item with the oldest predicted one.
// ----------------------------------------------------------------------------
module two_finger_tap_detector_core_tb;
  import tftd_pkg::*;

  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;

  localparam int SETTLE_CYCLES   = 2 + 4 * SLOTS + 8;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int RANDOM_ITEMS    = 1100;
  localparam int PHASE_ITEMS     = 185;
  localparam int TIMEOUT_EDGE_MS = 20;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = '1;
  localparam logic [MS_W-1:0]    TIMEOUT_MAX = '1;

  typedef struct packed {
    logic button_down;
    logic last_of_run;
  } click_t;

  localparam click_t CLICK_PRESS   = '{button_down: 1'b1, last_of_run: 1'b0};
  localparam click_t CLICK_RELEASE = '{button_down: 1'b0, last_of_run: 1'b1};

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [2:0]                func;
  logic signed [VALUE_W-1:0] value;
  logic                      out_valid;
  logic                      out_ready;
  logic                      button_down;
  logic                      last_of_run;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [LIMIT_W-1:0]        cfg_data;

  // Contact table and registers as the block should hold them
  logic                  tch_active [SLOTS];
  logic [VALUE_W-1:0]    tch_id     [SLOTS];
  logic [COORD_BITS-1:0] tch_x      [SLOTS];
  logic [COORD_BITS-1:0] tch_y      [SLOTS];
  logic [COORD_BITS-1:0] tch_x0     [SLOTS];
  logic [COORD_BITS-1:0] tch_y0     [SLOTS];
  int unsigned           tch_sel;
  logic [COUNT_W-1:0]    tch_fingers;
  logic                  tch_armed;
  logic                  tch_latched;
  logic [MS_W-1:0]       tch_ms;
  logic [LIMIT_W-1:0]    lim_sq;
  logic [MS_W-1:0]       tap_ms_max;

  click_t expected_clicks [$];
  int     errors         = 0;
  int     events_sent    = 0;
  int     quiet_cycles   = 0;
  bit     tx_idle_on     = 1'b1;
  bit     rx_idle_on     = 1'b1;
  int     hold_len       = 0;
  int     hold_seq       = 0;

  two_finger_tap_detector_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .button_down(button_down),
    .last_of_run(last_of_run),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic void reset_contacts();
    for (int s = 0; s < SLOTS; s++) begin
      tch_active[s] = 1'b0;
      tch_id[s]     = ID_NONE;
      tch_x[s]      = '0;
      tch_y[s]      = '0;
      tch_x0[s]     = '0;
      tch_y0[s]     = '0;
    end
    tch_sel     = 0;
    tch_fingers = '0;
    tch_armed   = 1'b0;
    tch_latched = 1'b0;
    tch_ms      = '0;
    lim_sq      = MOVE_LIMIT_RESET;
    tap_ms_max  = TIMEOUT_RESET;
  endfunction

  function automatic bit any_finger_moved();
    longint dx, dy;
    for (int s = 0; s < SLOTS; s++) begin
      if (tch_active[s]) begin
        dx = longint'(tch_x[s]) - longint'(tch_x0[s]);
        dy = longint'(tch_y[s]) - longint'(tch_y0[s]);
        if (dx * dx + dy * dy > longint'(lim_sq)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one item to the contact table and queue any click it causes
  function automatic void track_touch(input logic [2:0] f, input logic [VALUE_W-1:0] raw);
    int unsigned           s;
    logic [COORD_BITS-1:0] crd;
    s   = tch_sel;
    crd = raw[COORD_BITS-1:0];
    case (f)
      FN_SLOT: begin
        if (raw < SLOTS) tch_sel = int'(raw);
      end
      FN_TRACK: begin
        if (tch_id[s] != ID_NONE && raw == ID_NONE) begin
          if (tch_active[s]) begin
            if (tch_armed && tch_fingers == 2) begin
              if (tch_ms < tap_ms_max && !any_finger_moved()) begin
                expected_clicks.push_back(CLICK_PRESS);
                expected_clicks.push_back(CLICK_RELEASE);
              end
              tch_armed   = 1'b0;
              tch_latched = 1'b0;
            end
            tch_active[s] = 1'b0;
            tch_id[s]     = ID_NONE;
            if (tch_fingers > 0) tch_fingers--;
          end
        end else if (tch_id[s] == ID_NONE && raw != ID_NONE) begin
          if (!tch_active[s]) begin
            tch_active[s] = 1'b1;
            tch_id[s]     = raw;
            tch_x[s]      = '0;
            tch_y[s]      = '0;
            tch_x0[s]     = '0;
            tch_y0[s]     = '0;
            if (tch_fingers < 4'd15) tch_fingers++;
            if (tch_fingers == 2) begin
              tch_armed   = 1'b1;
              tch_ms      = '0;
              tch_latched = 1'b0;
            end else begin
              tch_armed = 1'b0;
            end
          end
        end
      end
      FN_POS_X: begin
        if (tch_active[s]) tch_x[s] = crd;
      end
      FN_POS_Y: begin
        if (tch_active[s]) tch_y[s] = crd;
      end
      FN_SYNC: begin
        if (tch_armed && tch_fingers == 2 && !tch_latched) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (tch_active[i]) begin
              tch_x0[i] = tch_x[i];
              tch_y0[i] = tch_y[i];
            end
          end
          tch_latched = 1'b1;
        end
        if (tch_fingers != 2 && tch_armed) begin
          tch_armed   = 1'b0;
          tch_latched = 1'b0;
        end
      end
      FN_TICK: begin
        if (tch_ms != TIMEOUT_MAX) tch_ms++;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    errors++;
  endtask

  // Offer one item; keep valid high from the previous item when there is no gap
  task automatic send_event(input logic [2:0] f, input logic [VALUE_W-1:0] v);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    track_touch(f, v);
    events_sent++;
  endtask

  task automatic sender_hold();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Drop valid, wait for every click, then let a lift check run out
  task automatic wait_for_clicks();
    sender_hold();
    while (expected_clicks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MOVE_LIMIT) lim_sq = data;
    else if (idx == REG_TIMEOUT) tap_ms_max = data[MS_W-1:0];
  endtask

  task automatic set_config(input logic [LIMIT_W-1:0] lim, input logic [MS_W-1:0] tmo);
    wait_for_clicks();
    write_reg(REG_MOVE_LIMIT, lim);
    write_reg(REG_TIMEOUT, LIMIT_W'(tmo));
  endtask

  // Call only with the sender held, so the wait cannot repeat an item
  task automatic hold_receiver(input int len);
    @(posedge clk);
    hold_len = len;
    hold_seq++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return VALUE_W'(16'hFFFF);
    if (r == 2) return VALUE_W'($urandom);
    return VALUE_W'($urandom_range(0, 65535));
  endfunction

  // Small step around a position, now and then a jump anywhere
  function automatic logic [VALUE_W-1:0] nudge(input logic [COORD_BITS-1:0] c);
    logic [COORD_BITS-1:0] n;
    if ($urandom_range(0, 3) == 0) return pick_coord();
    n = c + COORD_BITS'($urandom_range(0, 24)) - COORD_BITS'(12);
    return VALUE_W'(n);
  endfunction

  task automatic land_finger(input int s);
    logic [VALUE_W-1:0] id;
    id = ($urandom_range(0, 3) != 0) ? VALUE_W'($urandom_range(0, 65535)) : VALUE_W'($urandom);
    send_event(FN_SLOT, VALUE_W'(s));
    send_event(FN_TRACK, id);
    send_event(FN_POS_X, pick_coord());
    send_event(FN_POS_Y, pick_coord());
  endtask

  task automatic lift_finger(input int s);
    send_event(FN_SLOT, VALUE_W'(s));
    send_event(FN_TRACK, ID_NONE);
  endtask

  task automatic lift_all();
    for (int s = 0; s < SLOTS; s++) begin
      if (tch_active[s]) lift_finger(s);
    end
  endtask

  // Two fingers down, optional sync, ticks and moves mixed, then a lift
  task automatic run_tap_sequence();
    int s1, s2, s3, s, ticks_left, moves_left;
    if ($urandom_range(0, 3) != 0) lift_all();
    s1 = $urandom_range(0, SLOTS - 1);
    s2 = (s1 + $urandom_range(1, SLOTS - 1)) % SLOTS;
    land_finger(s1);
    land_finger(s2);
    if ($urandom_range(0, 7) == 0) begin
      s3 = s1;
      while (s3 == s1 || s3 == s2) s3 = $urandom_range(0, SLOTS - 1);
      land_finger(s3);
      if ($urandom_range(0, 1) == 0) lift_finger(s3);
    end
    if ($urandom_range(0, 3) != 0) send_event(FN_SYNC, VALUE_W'($urandom));
    ticks_left = $urandom_range(0, (tap_ms_max < 22) ? int'(tap_ms_max) + 2 : 24);
    moves_left = $urandom_range(0, 3);
    while (ticks_left > 0 || moves_left > 0) begin
      if (moves_left > 0 &&
          (ticks_left == 0 || $urandom_range(0, ticks_left + moves_left - 1) < moves_left)) begin
        s = ($urandom_range(0, 1) == 0) ? s1 : s2;
        send_event(FN_SLOT, VALUE_W'(s));
        if ($urandom_range(0, 1) == 0) send_event(FN_POS_X, nudge(tch_x[s]));
        else send_event(FN_POS_Y, nudge(tch_y[s]));
        if ($urandom_range(0, 5) == 0) send_event(FN_SYNC, VALUE_W'($urandom));
        moves_left--;
      end else begin
        send_event(FN_TICK, VALUE_W'($urandom));
        ticks_left--;
      end
    end
    s = ($urandom_range(0, 1) == 0) ? s1 : s2;
    lift_finger(s);
    if ($urandom_range(0, 1) == 0) lift_finger((s == s1) ? s2 : s1);
  endtask

  // Random items of any code, slot selects mostly in range
  task automatic run_noise(input int n);
    logic [2:0]         f;
    logic [VALUE_W-1:0] v;
    repeat (n) begin
      f = 3'($urandom_range(0, 7));
      v = VALUE_W'($urandom);
      if (f == FN_SLOT && $urandom_range(0, 3) != 0) v = VALUE_W'($urandom_range(0, SLOTS - 1));
      else if (f == FN_TRACK && $urandom_range(0, 1) == 0) v = ID_NONE;
      send_event(f, v);
    end
  endtask

  // Field extremes, ignored items, and a lift with and without latched starts
  task automatic test_directed_cases();
    send_event(FN_SPARE6, ID_NONE);
    send_event(FN_SPARE7, VALUE_W'(16'hFFFF));
    send_event(FN_SLOT, VALUE_W'(SLOTS));
    send_event(FN_SLOT, ID_NONE);
    send_event(FN_TRACK, ID_NONE);
    send_event(FN_POS_X, VALUE_W'(16'hFFFF));
    send_event(FN_TRACK, '0);
    send_event(FN_TRACK, VALUE_W'(16'hFFFF));
    send_event(FN_POS_X, VALUE_W'(16'hFFFF));
    send_event(FN_POS_Y, VALUE_W'(17'h10000));
    send_event(FN_SLOT, VALUE_W'(SLOTS - 1));
    send_event(FN_TRACK, VALUE_W'(16'hFFFF));
    send_event(FN_POS_X, '0);
    send_event(FN_POS_Y, ID_NONE);
    send_event(FN_TICK, '0);
    // Lift before any sync: starts are still zero, so both fingers moved
    send_event(FN_TRACK, ID_NONE);
    send_event(FN_TRACK, VALUE_W'(7));
    send_event(FN_SYNC, '0);
    send_event(FN_TICK, ID_NONE);
    // Still fingers after the sync: expect a click
    send_event(FN_TRACK, ID_NONE);
    lift_finger(0);
  endtask

  // Lift one tick short of the timeout, then right at it
  task automatic test_timeout_edge();
    set_config(LIMIT_MAX, MS_W'(TIMEOUT_EDGE_MS));
    for (int k = 0; k < 2; k++) begin
      lift_all();
      land_finger(0);
      land_finger(1);
      send_event(FN_SYNC, '0);
      repeat (TIMEOUT_EDGE_MS - 1 + k) send_event(FN_TICK, VALUE_W'($urandom));
      lift_finger(1);
      lift_finger(0);
    end
  endtask

  // Stall the receiver while taps keep coming, then pause until drained
  task automatic test_output_backpressure();
    set_config(LIMIT_MAX, TIMEOUT_MAX);
    tx_idle_on = 1'b0;
    hold_receiver(400);
    repeat (3) run_tap_sequence();
    wait_for_clicks();
    repeat (2) run_tap_sequence();
    wait_for_clicks();
    tx_idle_on = 1'b1;
  endtask

  // Phases of random taps and noise under rotating register settings
  task automatic test_random_taps();
    int phase, first, start;
    phase = 0;
    first = events_sent;
    while ((events_sent - first < RANDOM_ITEMS) && phase < 40) begin
      case (phase % 6)
        0: set_config(MOVE_LIMIT_RESET, TIMEOUT_RESET);
        1: set_config('0, '0);
        2: set_config(LIMIT_MAX, TIMEOUT_MAX);
        3: set_config(LIMIT_W'(150), MS_W'(12));
        4: set_config(LIMIT_W'(40000), MS_W'(1));
        default: set_config(LIMIT_W'(0), MS_W'(30));
      endcase
      tx_idle_on = (phase % 3 != 2);
      rx_idle_on = (phase % 4 != 3);
      start = events_sent;
      while (events_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) run_noise($urandom_range(1, 8));
        else run_tap_sequence();
      end
      phase++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : stimulus
    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = '0;
    value     = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_contacts();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_timeout_edge();
    test_output_backpressure();
    test_random_taps();
    wait_for_clicks();
    if (errors == 0) begin
      $display("two_finger_tap_detector_core verification clean");
    end else begin
      $display("two_finger_tap_detector_core verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold when one is requested
  initial begin : receiver
    int stall_left, hold_left, seen_seq;
    stall_left = 0;
    hold_left  = 0;
    seen_seq   = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (rx_idle_on) stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted click item with the oldest prediction
  always @(posedge clk) begin : click_checker
    click_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_clicks.size() == 0) begin
        report_mismatch($sformatf("click item (down %b, last %b) with nothing predicted",
                                  button_down, last_of_run));
      end else begin
        want = expected_clicks.pop_front();
        if (button_down !== want.button_down)
          report_mismatch($sformatf("button_down %b, predicted %b", button_down,
                                    want.button_down));
        if (last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, predicted %b", last_of_run,
                                    want.last_of_run));
      end
    end
  end

  // End the run when neither side has moved an item for too long
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("two_finger_tap_detector_core verification failed");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/tftd_pkg.sv
rtl/tftd_dist_unit.sv
rtl/two_finger_tap_detector_core.sv
verif/two_finger_tap_detector_core_tb.sv
